[rtl/lcdws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdws_pkg: shared types and constants of the character LCD write sequencer
// Request and result payloads, the internal command record, register indexes
// and reset values, and the request kind codes.
// ----------------------------------------------------------------------------
package lcdws_pkg;

	// Request kinds.
	localparam logic [2:0] KIND_COMMAND = 3'd0;
	localparam logic [2:0] KIND_DATA    = 3'd1;
	localparam logic [2:0] KIND_NIBBLE  = 3'd2;
	localparam logic [2:0] KIND_CURSOR  = 3'd3;
	localparam logic [2:0] KIND_GLYPH   = 3'd4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_WAIT         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETUP_WAIT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WAIT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POST_WAIT        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_SETUP_WAIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_POST_WAIT  = 3'd5;

	localparam int TICK_W = 16;

	// Register reset values.
	localparam logic [TICK_W-1:0] PRE_WAIT_RST         = 16'd200;
	localparam logic [TICK_W-1:0] SETUP_WAIT_RST       = 16'd7;
	localparam logic [TICK_W-1:0] PULSE_WAIT_RST       = 16'd7;
	localparam logic [TICK_W-1:0] POST_WAIT_RST        = 16'd200;
	localparam logic [TICK_W-1:0] START_SETUP_WAIT_RST = 16'd20;
	localparam logic [TICK_W-1:0] START_POST_WAIT_RST  = 16'd400;

	// Command byte prefixes.
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
	// Adding 64 to a 7-bit address flips its top bit.
	localparam logic [6:0] LINE2_OFFSET  = 7'h40;

	// Command queue geometry.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] byte_value;
		logic [5:0] column;
		logic [1:0] row;
		logic [2:0] glyph_index;
	} req_t;

	typedef struct packed {
		logic              reg_select;
		logic              enable_pin;
		logic [3:0]        bus_nibble;
		logic [TICK_W-1:0] hold_ticks;
		logic              last;
	} res_t;

	// One classified transfer as handed from the front end to the back end.
	typedef struct packed {
		logic       is_nibble;
		logic       rs;
		logic [7:0] data;
		logic [3:0] old_nibble;
	} cmd_t;

	typedef struct packed {
		logic [TICK_W-1:0] pre_wait;
		logic [TICK_W-1:0] setup_wait;
		logic [TICK_W-1:0] pulse_wait;
		logic [TICK_W-1:0] post_wait;
		logic [TICK_W-1:0] start_setup_wait;
		logic [TICK_W-1:0] start_post_wait;
	} cfg_t;

endpackage
`default_nettype wire

[rtl/lcdws_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdws_front: request decoder
// Turns each request into a command record and tracks the nibble left on
// the data pins.
// ----------------------------------------------------------------------------
module lcdws_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic              full,
	input  wire lcdws_pkg::req_t   request,
	output lcdws_pkg::cmd_t        enq_cmd,
	output logic                   enq
);

	logic [3:0]     bus_hold_q;
	logic           kind_ok;
	logic [6:0]     ddram_addr;
	lcdws_pkg::cmd_t cmd;

	always_comb begin
		ddram_addr = {1'b0, request.column} + 7'h7F;
		if (request.row[1]) begin
			ddram_addr = ddram_addr ^ lcdws_pkg::LINE2_OFFSET;
		end
		kind_ok        = 1'b1;
		cmd.is_nibble  = 1'b0;
		cmd.rs         = 1'b0;
		cmd.data       = request.byte_value;
		cmd.old_nibble = bus_hold_q;
		case (request.kind)
			lcdws_pkg::KIND_COMMAND: begin
			end
			lcdws_pkg::KIND_DATA: begin
				cmd.rs = 1'b1;
			end
			lcdws_pkg::KIND_NIBBLE: begin
				cmd.is_nibble = 1'b1;
				cmd.data      = {4'd0, request.byte_value[3:0]};
			end
			lcdws_pkg::KIND_CURSOR: begin
				cmd.data = lcdws_pkg::CMD_SET_DDRAM | {1'b0, ddram_addr};
			end
			lcdws_pkg::KIND_GLYPH: begin
				cmd.data = lcdws_pkg::CMD_SET_CGRAM | {2'd0, request.glyph_index, 3'd0};
			end
			default: begin
				kind_ok = 1'b0;
			end
		endcase
	end

	assign enq     = push && !full && kind_ok;
	assign enq_cmd = cmd;

	// Every transfer leaves its low nibble on the pins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_hold_q <= 4'd0;
		end else if (enq) begin
			bus_hold_q <= cmd.data[3:0];
		end
	end

endmodule
`default_nettype wire

[rtl/lcdws_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdws_queue: command queue
// Two-entry queue of command records between the decoder and the sequencer.
// ----------------------------------------------------------------------------
module lcdws_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire lcdws_pkg::cmd_t wr_cmd,
	input  wire logic            rd,
	output lcdws_pkg::cmd_t      head,
	output logic                 q_empty,
	output logic                 q_full
);

	lcdws_pkg::cmd_t                 mem [lcdws_pkg::Q_DEPTH];
	logic [lcdws_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [lcdws_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [lcdws_pkg::Q_CNT_W-1:0]   count_q;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == lcdws_pkg::Q_CNT_W'(lcdws_pkg::Q_DEPTH));
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/lcdws_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdws_back: pin-state sequencer
// Steps through the pin states of the command at the queue head into the
// result register, one state per cycle while the result is empty or popped.
// ----------------------------------------------------------------------------
module lcdws_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lcdws_pkg::cfg_t cfg,
	input  wire lcdws_pkg::cmd_t head,
	input  wire logic            q_empty,
	output logic                 deq,
	input  wire logic            pop,
	output logic                 empty,
	output lcdws_pkg::res_t      result
);

	typedef enum logic [2:0] {
		ST_SETTLE,
		ST_HI_SETUP,
		ST_HI_PULSE,
		ST_LO_SETUP,
		ST_LO_PULSE,
		ST_POST
	} step_t;

	step_t           step_q;
	step_t           step_nx;
	lcdws_pkg::res_t res;
	lcdws_pkg::res_t out_q;
	logic            out_valid_q;
	logic            emit;

	// Pin state for the current step. A start-up nibble uses only the first
	// three steps.
	always_comb begin
		res.reg_select = head.rs;
		res.enable_pin = 1'b0;
		res.bus_nibble = head.data[3:0];
		res.hold_ticks = cfg.setup_wait;
		res.last       = 1'b0;
		step_nx        = ST_SETTLE;
		if (head.is_nibble) begin
			case (step_q)
				ST_SETTLE: begin
					res.hold_ticks = cfg.start_setup_wait;
					step_nx        = ST_HI_SETUP;
				end
				ST_HI_SETUP: begin
					res.enable_pin = 1'b1;
					res.hold_ticks = cfg.start_setup_wait;
					step_nx        = ST_HI_PULSE;
				end
				default: begin
					res.hold_ticks = cfg.start_post_wait;
					res.last       = 1'b1;
				end
			endcase
		end else begin
			case (step_q)
				ST_SETTLE: begin
					res.bus_nibble = head.old_nibble;
					res.hold_ticks = cfg.pre_wait;
					step_nx        = ST_HI_SETUP;
				end
				ST_HI_SETUP: begin
					res.bus_nibble = head.data[7:4];
					step_nx        = ST_HI_PULSE;
				end
				ST_HI_PULSE: begin
					res.bus_nibble = head.data[7:4];
					res.enable_pin = 1'b1;
					res.hold_ticks = cfg.pulse_wait;
					step_nx        = ST_LO_SETUP;
				end
				ST_LO_SETUP: begin
					step_nx = ST_LO_PULSE;
				end
				ST_LO_PULSE: begin
					res.enable_pin = 1'b1;
					res.hold_ticks = cfg.pulse_wait;
					step_nx        = ST_POST;
				end
				default: begin
					res.hold_ticks = cfg.post_wait;
					res.last       = 1'b1;
				end
			endcase
		end
	end

	assign emit   = !q_empty && (!out_valid_q || pop);
	assign deq    = emit && res.last;
	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_SETTLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit) begin
				step_q      <= step_nx;
				out_q       <= res;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/char_lcd_nibble_write_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_core: 4-bit character LCD write sequencer
// Turns command, data, start-up nibble, cursor and glyph address requests
// into timed pin states (RS, E, D7..D4 and a hold time) for a 4-bit bus.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                        Transfers when
//   --------  -----------------------------  -------------------------------
//   request   push, full, request            push high and full low
//   result    pop, empty, result             pop high and empty low
//   config    cfg_write, cfg_index, cfg_data cfg_write high
//
// A command, data, cursor or glyph request yields six pin states and a start-up
// nibble three, one per cycle while pop is held; unused kinds are taken and dropped.
// From an idle queue the request is first written to a queue entry, then registered.
// The two-entry command queue takes new requests while one is sequenced, and full
// rises when both entries are occupied. A result left unpopped holds the sequencer's step.
// Reset loads the register defaults, empties the queue and clears the held nibble.
//
module char_lcd_nibble_write_sequencer_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire lcdws_pkg::req_t                   request,
	input  wire logic                              pop,
	output logic                                   empty,
	output lcdws_pkg::res_t                        result,
	input  wire logic                              cfg_write,
	input  wire logic [lcdws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lcdws_pkg::TICK_W-1:0]      cfg_data
);

	lcdws_pkg::cfg_t cfg_q;
	lcdws_pkg::cmd_t enq_cmd;
	lcdws_pkg::cmd_t head;
	logic            enq;
	logic            deq;
	logic            q_empty;
	logic            q_full;

	// Timing registers. Writes to an index past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_wait         <= lcdws_pkg::PRE_WAIT_RST;
			cfg_q.setup_wait       <= lcdws_pkg::SETUP_WAIT_RST;
			cfg_q.pulse_wait       <= lcdws_pkg::PULSE_WAIT_RST;
			cfg_q.post_wait        <= lcdws_pkg::POST_WAIT_RST;
			cfg_q.start_setup_wait <= lcdws_pkg::START_SETUP_WAIT_RST;
			cfg_q.start_post_wait  <= lcdws_pkg::START_POST_WAIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				lcdws_pkg::REG_PRE_WAIT:         cfg_q.pre_wait         <= cfg_data;
				lcdws_pkg::REG_SETUP_WAIT:       cfg_q.setup_wait       <= cfg_data;
				lcdws_pkg::REG_PULSE_WAIT:       cfg_q.pulse_wait       <= cfg_data;
				lcdws_pkg::REG_POST_WAIT:        cfg_q.post_wait        <= cfg_data;
				lcdws_pkg::REG_START_SETUP_WAIT: cfg_q.start_setup_wait <= cfg_data;
				lcdws_pkg::REG_START_POST_WAIT:  cfg_q.start_post_wait  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The request side is full exactly when the command queue is full.
	assign full = q_full;

	// The decoder classifies each request and records the nibble that the
	// previous transfer left on the pins, so the settle state is known
	// without waiting for the sequencer.
	lcdws_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (q_full),
		.request (request),
		.enq_cmd (enq_cmd),
		.enq     (enq)
	);

	lcdws_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (enq),
		.wr_cmd  (enq_cmd),
		.rd      (deq),
		.head    (head),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	// The sequencer releases a queue entry on the cycle it emits that
	// command's final pin state.
	lcdws_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_empty),
		.deq     (deq),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

`ifndef SYNTH
	// A queue entry is released only together with its final pin state.
	assert property (@(posedge clk) disable iff (!arst_n)
		deq |=> (!empty && result.last))
		else $error("queue entry released without a final pin state");

	// A decoded request is in the queue on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		enq |=> !q_empty)
		else $error("decoded request missing from queue");

	// A stalled request side always has work waiting for the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !q_empty)
		else $error("request side full while queue is empty");
`endif

endmodule
`default_nettype wire
